// ===== rtl/m7irc_pkg.sv =====
// Shared constants and lookup tables for the median-filtered IR range converter.
// Depends on nothing; the top level refers to it by scoped names.
package m7irc_pkg;

	// Window and channel geometry.
	localparam int WINDOW       = 7;
	localparam int CHANNELS     = 4;
	localparam int SAMPLE_BITS  = 10;
	localparam int SHORT_POINTS = 16;
	localparam int LONG_POINTS  = 9;
	localparam int SHORT_USED   = (SHORT_POINTS < 16) ? SHORT_POINTS : 16;
	localparam int LONG_USED    = (LONG_POINTS < 9) ? LONG_POINTS : 9;
	localparam int CH_W         = 2;
	localparam int MED_RANK     = WINDOW / 2;
	localparam int RANK_W       = $clog2(WINDOW);
	localparam int BIT_CNT_W    = $clog2(SAMPLE_BITS + 1);
	localparam int LONG_CHANNEL = 3;

	// Beat kinds carried in tuser.
	localparam logic FUNC_PUSH  = 1'b0;
	localparam logic FUNC_QUERY = 1'b1;

	// Voltage comparison: code * 5000 against millivolts * full-scale code.
	localparam int MV_W      = 12;
	localparam int VS_SCALE  = 5000;
	localparam int VS_W      = SAMPLE_BITS + 13;
	localparam int LO_W      = MV_W + SAMPLE_BITS;
	localparam int CODE_FULL = (1 << SAMPLE_BITS) - 1;

	// Serial divider and conversion widths.
	localparam int INV_W      = 24;
	localparam int NUM_W      = 41;
	localparam int DEN_W      = 24;
	localparam int DIV_CNT_W  = $clog2(NUM_W + 1);
	localparam int CM_SHIFT   = 40;
	localparam int OFFSET_Q16 = 27525;
	localparam int INCH_MUL   = 3937;
	localparam int INCH_DIV   = 2560000;
	localparam int DIST_W     = 16;
	localparam int SEG_W      = 4;
	localparam int TBL_DEPTH  = 16;

	// Segment breakpoints in millivolts.
	localparam logic [MV_W-1:0] SHORT_MV [TBL_DEPTH] = '{
		12'd380, 12'd410, 12'd520, 12'd640, 12'd805, 12'd920, 12'd1060, 12'd1250,
		12'd1580, 12'd1780, 12'd2010, 12'd2330, 12'd2620, 12'd3000, 12'd3020, 12'd2215};
	localparam logic [MV_W-1:0] LONG_MV [TBL_DEPTH] = '{
		12'd420, 12'd650, 12'd1080, 12'd1250, 12'd1550, 12'd2000, 12'd2540, 12'd2780,
		12'd2300, 12'd0, 12'd0, 12'd0, 12'd0, 12'd0, 12'd0, 12'd0};

	// Inverse distance at each breakpoint, Q0.24 per centimetre.
	localparam logic [INV_W-1:0] SHORT_INV [TBL_DEPTH] = '{
		24'd415072, 24'd551519, 24'd660001, 24'd821607, 24'd1021755, 24'd1163469,
		24'd1350823, 24'd1610098, 24'd1992543, 24'd2261080, 24'd2613274, 24'd3095427,
		24'd3795750, 24'd4279902, 24'd4905619, 24'd6932734};
	localparam logic [INV_W-1:0] LONG_INV [TBL_DEPTH] = '{
		24'd111848, 24'd167772, 24'd279620, 24'd335544, 24'd419430, 24'd559241,
		24'd838861, 24'd1118481, 24'd1677722, 24'd0, 24'd0, 24'd0, 24'd0, 24'd0,
		24'd0, 24'd0};

	function automatic logic [MV_W-1:0] tbl_mv(input logic use_long,
			input logic [SEG_W-1:0] idx);
		tbl_mv = use_long ? LONG_MV[idx] : SHORT_MV[idx];
	endfunction

	function automatic logic [INV_W-1:0] tbl_inv(input logic use_long,
			input logic [SEG_W-1:0] idx);
		tbl_inv = use_long ? LONG_INV[idx] : SHORT_INV[idx];
	endfunction

endpackage

// ===== rtl/median7_ir_range_converter.sv =====
// Top level of the median-filtered IR range converter: windows, bit-serial median,
// segment search and a shared bit-serial divider. Uses m7irc_pkg.

// A push beat (tuser 0) stores a sample in its channel's seven-sample window. A query
// beat (tuser 1) takes the median bit by bit, one code bit per cycle, scans the table
// one segment per cycle (up to 15 segments), and then runs up to three passes of the
// single restoring divider for interpolation, reciprocal and inch conversion, each
// 41 quotient bits. The input takes no new beat while a query is in flight; the
// result is held in an output register until it is taken.
module median7_ir_range_converter (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [15:0] s_tdata,   // [1:0] channel, [11:2] sample, rest zero
	input  logic [0:0]  s_tuser,   // [0] func
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,   // [15:0] distance_q8, [25:16] median_code, rest zero
	output logic [0:0]  m_tuser    // [0] out_of_range
);

	localparam int SB = m7irc_pkg::SAMPLE_BITS;

	typedef enum logic [3:0] {
		ST_IDLE, ST_MED, ST_VS, ST_SEARCH, ST_MUL, ST_DIV_INV,
		ST_DIV_CM, ST_MUL_IN, ST_DIV_IN, ST_DONE
	} state_t;

	state_t state_q;

	logic [SB-1:0] win_q [m7irc_pkg::CHANNELS][m7irc_pkg::WINDOW];
	logic [SB-1:0] work_q [m7irc_pkg::WINDOW];
	logic [m7irc_pkg::WINDOW-1:0] active_q;
	logic [m7irc_pkg::RANK_W-1:0] rank_q;
	logic [m7irc_pkg::BIT_CNT_W-1:0] bit_cnt_q;
	logic [SB-1:0] med_q;
	logic use_long_q;
	logic [m7irc_pkg::VS_W-1:0] vs_q;
	logic [m7irc_pkg::SEG_W-1:0] seg_q;
	logic [m7irc_pkg::INV_W-1:0] x_q, dx_q;
	logic [m7irc_pkg::VS_W-1:0] vsd_q;
	logic [m7irc_pkg::NUM_W-1:0] num_q;
	logic [m7irc_pkg::DEN_W-1:0] den_q, rem_q;
	logic [m7irc_pkg::DIV_CNT_W-1:0] div_cnt_q;
	logic [m7irc_pkg::INV_W-1:0] cm_q;
	logic [m7irc_pkg::DIST_W-1:0] dist_q;
	logic oor_q;
	logic m_tvalid_q;
	logic [31:0] m_tdata_q;
	logic m_tuser_q;

	logic s_fire;
	logic func;
	logic [m7irc_pkg::CH_W-1:0] channel;
	logic [SB-1:0] sample;

	assign s_tready = (state_q == ST_IDLE);
	assign s_fire   = s_tvalid && s_tready;
	assign func     = s_tuser[0];
	assign channel  = s_tdata[m7irc_pkg::CH_W-1:0];
	assign sample   = s_tdata[m7irc_pkg::CH_W +: SB];
	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tuser  = m_tuser_q;

	// Median step: count live candidates whose current top bit is zero.
	logic [m7irc_pkg::WINDOW-1:0] zero_vec, one_vec;
	logic [m7irc_pkg::RANK_W:0] zeros;
	logic med_bit;
	always_comb begin
		for (int j = 0; j < m7irc_pkg::WINDOW; j++) begin
			zero_vec[j] = active_q[j] & ~work_q[j][SB-1];
			one_vec[j]  = active_q[j] & work_q[j][SB-1];
		end
		zeros   = (m7irc_pkg::RANK_W + 1)'($countones(zero_vec));
		med_bit = !({1'b0, rank_q} < zeros);
	end

	// Segment bracketing test for the current index.
	logic [m7irc_pkg::SEG_W-1:0] seg_next, last_seg;
	logic [m7irc_pkg::LO_W-1:0] lo, hi;
	logic bracket;
	always_comb begin
		seg_next = seg_q + m7irc_pkg::SEG_W'(1);
		last_seg = use_long_q ? m7irc_pkg::SEG_W'(m7irc_pkg::LONG_USED - 2)
		                      : m7irc_pkg::SEG_W'(m7irc_pkg::SHORT_USED - 2);
		lo = m7irc_pkg::LO_W'(m7irc_pkg::tbl_mv(use_long_q, seg_q) * m7irc_pkg::CODE_FULL);
		hi = m7irc_pkg::LO_W'(m7irc_pkg::tbl_mv(use_long_q, seg_next) * m7irc_pkg::CODE_FULL);
		bracket = (m7irc_pkg::VS_W'(lo) <= vs_q) && (vs_q <= m7irc_pkg::VS_W'(hi));
	end

	// One restoring division step: shift in a numerator bit, subtract if it fits.
	logic [m7irc_pkg::DEN_W:0] trial;
	logic [m7irc_pkg::DEN_W-1:0] rem_next;
	logic q_bit;
	logic [m7irc_pkg::INV_W-1:0] inv;
	always_comb begin
		trial = {rem_q, num_q[m7irc_pkg::NUM_W-1]};
		q_bit = (trial >= {1'b0, den_q});
		rem_next = q_bit ? m7irc_pkg::DEN_W'(trial - {1'b0, den_q})
		                 : trial[m7irc_pkg::DEN_W-1:0];
		inv = x_q + num_q[m7irc_pkg::INV_W-1:0];
	end

	// Sample windows: a push shifts the oldest sample out of its channel.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int c = 0; c < m7irc_pkg::CHANNELS; c++)
				for (int k = 0; k < m7irc_pkg::WINDOW; k++)
					win_q[c][k] <= '0;
		end else if (s_fire && func == m7irc_pkg::FUNC_PUSH) begin
			for (int k = 0; k < m7irc_pkg::WINDOW - 1; k++)
				win_q[channel][k] <= win_q[channel][k + 1];
			win_q[channel][m7irc_pkg::WINDOW - 1] <= sample;
		end
	end

	// Query sequencer and output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			m_tvalid_q <= 1'b0;
			m_tdata_q  <= '0;
			m_tuser_q  <= 1'b0;
			for (int j = 0; j < m7irc_pkg::WINDOW; j++)
				work_q[j] <= '0;
			active_q   <= '0;
			rank_q     <= '0;
			bit_cnt_q  <= '0;
			med_q      <= '0;
			use_long_q <= 1'b0;
			vs_q       <= '0;
			seg_q      <= '0;
			x_q        <= '0;
			dx_q       <= '0;
			vsd_q      <= '0;
			num_q      <= '0;
			den_q      <= '0;
			rem_q      <= '0;
			div_cnt_q  <= '0;
			cm_q       <= '0;
			dist_q     <= '0;
			oor_q      <= 1'b0;
		end else begin
			if (m_tvalid_q && m_tready)
				m_tvalid_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (s_fire && func == m7irc_pkg::FUNC_QUERY) begin
						for (int j = 0; j < m7irc_pkg::WINDOW; j++)
							work_q[j] <= win_q[channel][j];
						active_q   <= '1;
						rank_q     <= m7irc_pkg::RANK_W'(m7irc_pkg::MED_RANK);
						bit_cnt_q  <= m7irc_pkg::BIT_CNT_W'(SB);
						use_long_q <= (channel == m7irc_pkg::CH_W'(m7irc_pkg::LONG_CHANNEL));
						state_q    <= ST_MED;
					end
				end
				ST_MED: begin
					for (int j = 0; j < m7irc_pkg::WINDOW; j++)
						work_q[j] <= {work_q[j][SB-2:0], 1'b0};
					if (med_bit) begin
						active_q <= one_vec;
						rank_q   <= m7irc_pkg::RANK_W'({1'b0, rank_q} - zeros);
					end else begin
						active_q <= zero_vec;
					end
					med_q     <= {med_q[SB-2:0], med_bit};
					bit_cnt_q <= bit_cnt_q - m7irc_pkg::BIT_CNT_W'(1);
					if (bit_cnt_q == m7irc_pkg::BIT_CNT_W'(1))
						state_q <= ST_VS;
				end
				ST_VS: begin
					vs_q    <= m7irc_pkg::VS_W'(med_q * m7irc_pkg::VS_SCALE);
					seg_q   <= '0;
					state_q <= ST_SEARCH;
				end
				ST_SEARCH: begin
					if (bracket) begin
						x_q   <= m7irc_pkg::tbl_inv(use_long_q, seg_q);
						dx_q  <= m7irc_pkg::tbl_inv(use_long_q, seg_next)
						         - m7irc_pkg::tbl_inv(use_long_q, seg_q);
						vsd_q <= vs_q - m7irc_pkg::VS_W'(lo);
						den_q <= m7irc_pkg::DEN_W'(hi - lo);
						state_q <= ST_MUL;
					end else if (seg_q == last_seg) begin
						dist_q  <= '0;
						oor_q   <= 1'b1;
						state_q <= ST_DONE;
					end else begin
						seg_q <= seg_next;
					end
				end
				ST_MUL: begin
					// A flat segment never occurs in the tables, so span is non-zero.
					num_q     <= m7irc_pkg::NUM_W'(dx_q) * m7irc_pkg::NUM_W'(vsd_q);
					rem_q     <= '0;
					div_cnt_q <= m7irc_pkg::DIV_CNT_W'(m7irc_pkg::NUM_W);
					state_q   <= ST_DIV_INV;
				end
				ST_DIV_INV, ST_DIV_CM, ST_DIV_IN: begin
					if (div_cnt_q != '0) begin
						num_q     <= {num_q[m7irc_pkg::NUM_W-2:0], q_bit};
						rem_q     <= rem_next;
						div_cnt_q <= div_cnt_q - m7irc_pkg::DIV_CNT_W'(1);
					end else if (state_q == ST_DIV_INV) begin
						// Quotient is the interpolation step; next take 2^40 / inv.
						num_q     <= m7irc_pkg::NUM_W'(1) << m7irc_pkg::CM_SHIFT;
						den_q     <= inv;
						rem_q     <= '0;
						div_cnt_q <= m7irc_pkg::DIV_CNT_W'(m7irc_pkg::NUM_W);
						state_q   <= ST_DIV_CM;
					end else if (state_q == ST_DIV_CM) begin
						cm_q <= num_q[m7irc_pkg::INV_W-1:0];
						if (num_q <= m7irc_pkg::NUM_W'(m7irc_pkg::OFFSET_Q16)) begin
							dist_q  <= '0;
							oor_q   <= 1'b0;
							state_q <= ST_DONE;
						end else begin
							state_q <= ST_MUL_IN;
						end
					end else begin
						oor_q <= 1'b0;
						if (num_q[m7irc_pkg::NUM_W-1:m7irc_pkg::DIST_W] != '0)
							dist_q <= '1;
						else
							dist_q <= num_q[m7irc_pkg::DIST_W-1:0];
						state_q <= ST_DONE;
					end
				end
				ST_MUL_IN: begin
					num_q <= m7irc_pkg::NUM_W'(cm_q - m7irc_pkg::INV_W'(m7irc_pkg::OFFSET_Q16))
					         * m7irc_pkg::NUM_W'(m7irc_pkg::INCH_MUL);
					den_q     <= m7irc_pkg::DEN_W'(m7irc_pkg::INCH_DIV);
					rem_q     <= '0;
					div_cnt_q <= m7irc_pkg::DIV_CNT_W'(m7irc_pkg::NUM_W);
					state_q   <= ST_DIV_IN;
				end
				ST_DONE: begin
					if (!m_tvalid_q || m_tready) begin
						m_tvalid_q <= 1'b1;
						m_tdata_q  <= {6'd0, med_q, dist_q};
						m_tuser_q  <= oor_q;
						state_q    <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

`ifndef SYNTHESIS
	// An out-of-range result always reports zero distance.
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[0] |-> m_tdata[15:0] == 16'd0)
		else $error("out-of-range result with non-zero distance");

	// The median search always keeps more live candidates than the remaining rank.
	assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_MED |-> $countones(active_q) > rank_q)
		else $error("median candidate set exhausted");

	// A finished result never overwrites one that has not been taken.
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("pending result overwritten");
`endif

endmodule

// ===== bench/tb.sv =====
// Self-checking bench for median7_ir_range_converter: pushes and queries on the
// input stream, with an in-bench predictor of median and distance. Uses m7irc_pkg.
`timescale 1ns / 1ps

module tb;

	localparam int STALL_LIMIT = 20000;

	typedef struct packed {
		logic [15:0] distance;
		logic [9:0]  med;
		logic        oor;
	} range_t;

	// Predicts ranges from accepted beats and checks them against returned beats.
	class range_scoreboard;
		logic [9:0] win [m7irc_pkg::CHANNELS][m7irc_pkg::WINDOW];
		int fill [m7irc_pkg::CHANNELS];
		range_t pending [$];
		int errors;

		function new();
			errors = 0;
			foreach (fill[c]) begin
				fill[c] = 0;
				foreach (win[c][k]) win[c][k] = '0;
			end
		endfunction

		function longint inv_of(longint den);
			return (64'd1677721600 + den / 2) / den;
		endfunction

		function range_t lookup(logic [9:0] code, bit use_long);
			longint mv [16];
			longint den [16];
			longint vs, lo, hi, x, x1, inv, cm, r;
			int n;
			range_t res;
			mv = '{380, 410, 520, 640, 805, 920, 1060, 1250, 1580, 1780, 2010, 2330,
				2620, 3000, 3020, 2215};
			den = '{4042, 3042, 2542, 2042, 1642, 1442, 1242, 1042, 842, 742, 642,
				542, 442, 392, 342, 242};
			n = m7irc_pkg::SHORT_USED;
			if (use_long) begin
				mv = '{420, 650, 1080, 1250, 1550, 2000, 2540, 2780, 2300, 0, 0, 0, 0,
					0, 0, 0};
				den = '{15000, 10000, 6000, 5000, 4000, 3000, 2000, 1500, 1000, 1, 1,
					1, 1, 1, 1, 1};
				n = m7irc_pkg::LONG_USED;
			end
			res.med = code;
			res.distance = '0;
			res.oor = 1'b1;
			vs = longint'(code) * 5000;
			for (int i = 0; i + 1 < n; i++) begin
				lo = mv[i] * m7irc_pkg::CODE_FULL;
				hi = mv[i + 1] * m7irc_pkg::CODE_FULL;
				if (lo <= vs && vs <= hi) begin
					x = inv_of(den[i]);
					x1 = inv_of(den[i + 1]);
					inv = x;
					if (hi != lo) inv = x + ((x1 - x) * (vs - lo)) / (hi - lo);
					if (inv <= 0) inv = 1;
					cm = (longint'(1) << 40) / inv;
					r = 0;
					if (cm > m7irc_pkg::OFFSET_Q16)
						r = ((cm - m7irc_pkg::OFFSET_Q16) * 3937) / 2560000;
					if (r > 65535) r = 65535;
					res.distance = r[15:0];
					res.oor = 1'b0;
					return res;
				end
			end
			return res;
		endfunction

		function void note_input(bit func, logic [1:0] ch, logic [9:0] smp);
			logic [9:0] t [m7irc_pkg::WINDOW];
			logic [9:0] sw;
			int m;
			if (func == m7irc_pkg::FUNC_PUSH) begin
				if (ch >= m7irc_pkg::CHANNELS) return;
				if (fill[ch] >= m7irc_pkg::WINDOW) begin
					for (int k = 0; k + 1 < m7irc_pkg::WINDOW; k++)
						win[ch][k] = win[ch][k + 1];
					fill[ch] = m7irc_pkg::WINDOW - 1;
				end
				win[ch][fill[ch]] = smp;
				fill[ch]++;
				return;
			end
			if (ch >= m7irc_pkg::CHANNELS) begin
				pending.push_back('{16'd0, 10'd0, 1'b1});
				return;
			end
			// Selection sort of a copy of the window; the median sits mid-way.
			for (int a = 0; a < m7irc_pkg::WINDOW; a++) t[a] = win[ch][a];
			for (int a = 0; a < m7irc_pkg::WINDOW; a++) begin
				m = a;
				for (int b = a + 1; b < m7irc_pkg::WINDOW; b++) if (t[b] < t[m]) m = b;
				sw = t[a]; t[a] = t[m]; t[m] = sw;
			end
			pending.push_back(lookup(t[m7irc_pkg::MED_RANK],
				ch == 2'(m7irc_pkg::LONG_CHANNEL)));
		endfunction

		function void check_result(logic [31:0] data, logic oor);
			range_t exp;
			if (pending.size() == 0) begin
				errors++;
				if (errors <= 10) $display("unexpected result beat %h", data);
				return;
			end
			exp = pending.pop_front();
			if (data !== {6'd0, exp.med, exp.distance} || oor !== exp.oor) begin
				errors++;
				if (errors <= 10)
					$display("result: expected dist %h med %h oor %b, got %h oor %b",
						exp.distance, exp.med, exp.oor, data, oor);
			end
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [15:0] s_tdata = '0;
	logic [0:0] s_tuser = '0;
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [31:0] m_tdata;
	logic [0:0] m_tuser;

	range_scoreboard ranges = new();
	bit feeding_done = 0;
	bit hold_off = 0;
	int quiet_cycles = 0;

	median7_ir_range_converter i_dut (.*);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// Gap length: mostly none or short, now and then long.
	function int gap_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 50) return 0;
		if (r < 95) return $urandom_range(1, 4);
		return $urandom_range(20, 200);
	endfunction

	// Offer one beat and hold it until accepted.
	task send_beat(bit func, logic [1:0] ch, logic [9:0] smp);
		@(negedge clk);
		s_tvalid <= 1'b1;
		s_tuser <= func;
		s_tdata <= {4'd0, smp, ch};
		do @(posedge clk); while (!s_tready);
		ranges.note_input(func, ch, smp);
		@(negedge clk);
		s_tvalid <= 1'b0;
	endtask

	task idle_for(int n);
		repeat (n) @(negedge clk);
	endtask

	task fill_window(logic [1:0] ch, logic [9:0] smp);
		repeat (m7irc_pkg::WINDOW) send_beat(m7irc_pkg::FUNC_PUSH, ch, smp);
	endtask

	// Stimulus: directed extremes, then mostly push-and-query sequences.
	initial begin
		int n;
		repeat (7) @(posedge clk);
		@(negedge clk) arst_n <= 1'b1;
		// Empty windows give a median of zero, below every table.
		send_beat(m7irc_pkg::FUNC_QUERY, 2'd0, 10'd0);
		send_beat(m7irc_pkg::FUNC_QUERY, 2'd3, 10'h3ff);
		fill_window(2'd1, 10'h3ff);
		send_beat(m7irc_pkg::FUNC_QUERY, 2'd1, 10'd0);
		// Near the top of the short table, and inside the long table.
		fill_window(2'd2, 10'd614);
		send_beat(m7irc_pkg::FUNC_QUERY, 2'd2, 10'd0);
		fill_window(2'd3, 10'd500);
		send_beat(m7irc_pkg::FUNC_QUERY, 2'd3, 10'h155);
		send_beat(m7irc_pkg::FUNC_PUSH, 2'd3, 10'd86);
		send_beat(m7irc_pkg::FUNC_QUERY, 2'd3, 10'h2aa);
		// Random part.
		n = 0;
		while (n < 2000) begin
			if ($urandom_range(0, 9) < 8) begin
				logic [1:0] ch;
				ch = 2'($urandom_range(0, 3));
				repeat ($urandom_range(1, 9)) begin
					send_beat(m7irc_pkg::FUNC_PUSH, ch, $urandom_range(0, 3) == 0 ?
						10'($urandom) : 10'($urandom_range(60, 640)));
					n++;
					idle_for(gap_len());
				end
				send_beat(m7irc_pkg::FUNC_QUERY, ch, 10'($urandom));
			end else begin
				send_beat(1'($urandom), 2'($urandom), 10'($urandom));
			end
			n++;
			if (n > 1000 && n < 1020) hold_off = 1;
			idle_for(gap_len());
		end
		feeding_done = 1;
	end

	// Receiver: random stalls, plus long hold-offs while input keeps coming.
	initial begin
		int stall;
		wait (arst_n);
		forever begin
			@(negedge clk);
			if (hold_off) begin
				m_tready <= 1'b0;
				repeat (600) @(negedge clk);
				hold_off = 0;
			end
			stall = gap_len();
			if (stall > 0) begin
				m_tready <= 1'b0;
				idle_for(stall - 1);
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	// Check at the rising edge.
	always @(posedge clk) begin
		if (m_tvalid && m_tready) ranges.check_result(m_tdata, m_tuser[0]);
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet_cycles <= 0;
		else quiet_cycles <= quiet_cycles + 1;
	end

	// End of run and watchdog.
	initial begin
		bit timed_out;
		timed_out = 0;
		fork
			begin
				wait (feeding_done && ranges.pending.size() == 0);
				repeat (400) @(posedge clk);
			end
			begin
				wait (quiet_cycles >= STALL_LIMIT);
				timed_out = 1;
			end
		join_any
		if (timed_out || ranges.errors != 0 || ranges.pending.size() != 0)
			$display("median7_ir_range_converter: mismatch");
		else
			$display("median7_ir_range_converter: match");
		$finish;
	end

endmodule

// ===== median7_ir_range_converter.f =====
rtl/m7irc_pkg.sv
rtl/median7_ir_range_converter.sv
bench/tb.sv
